// ===== src/nsrs_pkg.sv =====
`timescale 1ns / 1ps
package nsrs_pkg;

  localparam int VW      = 32;
  localparam int COEF_W  = 16;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 16;
  localparam int SXY_W   = 7;
  localparam int SZ_W    = 13;
  localparam int LIMIT_Z = 4096;
  localparam int PROD_W  = 49;
  localparam int ACC_W   = 56;
  localparam int SUM_W   = 41;
  localparam int SQ_W    = 66;
  localparam int REM_W   = 35;

  localparam logic [4:0] LAST_STEP  = 5'd18;
  localparam logic [4:0] DRAIN_LAST = 5'd2;
  localparam logic [4:0] SQ_LAST    = 5'd3;
  localparam logic [4:0] ROOT_LAST  = 5'd16;

  typedef enum logic [2:0] {
    REG_COEF_PAIR  = 3'd0,
    REG_COEF_FACE  = 3'd1,
    REG_COEF_CROSS = 3'd2,
    REG_SIZE_X     = 3'd3,
    REG_SIZE_Y     = 3'd4,
    REG_SIZE_Z     = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    CSEL_PAIR  = 2'd0,
    CSEL_FACE  = 2'd1,
    CSEL_CROSS = 2'd2
  } csel_t;

  typedef enum logic [1:0] {
    SRC_X    = 2'd0,
    SRC_Y    = 2'd1,
    SRC_Z    = 2'd2,
    SRC_NONE = 2'd3
  } src_t;

  typedef struct packed {
    logic  use_en;
    src_t  src;
    csel_t csel;
    logic  neg;
  } lane_ctl_t;

  typedef struct packed {
    logic       take;
    logic       rd_issue;
    logic [4:0] rd_step;
    logic       acc_clr;
    logic       fin1;
    logic       fin2;
    logic       fin3;
    logic       sq_en;
    logic [1:0] sq_idx;
    logic       root_init;
    logic       root_step;
    logic       wb;
  } cmd_t;

  typedef struct packed {
    logic emit_ok;
    logic boundary;
    logic out_free;
  } stat_t;

  // Neighbor nb (0..17) contribution to result lane (0..2).
  function automatic lane_ctl_t lane_ctl(input logic [4:0] nb, input logic [1:0] lane);
    lane_ctl_t c;
    logic [3:0] grp;
    grp = nb[4:1];
    c.use_en = 1'b1;
    c.src    = src_t'(lane);
    c.csel   = CSEL_CROSS;
    c.neg    = (grp == 4'd4) || (grp == 4'd6) || (grp == 4'd8);
    case (grp)
      4'd0: begin
        c.csel = CSEL_PAIR;
      end
      4'd1, 4'd2: begin
        c.csel = CSEL_FACE;
      end
      4'd3, 4'd4: begin
        case (lane)
          2'd0: c.src = SRC_Y;
          2'd1: c.src = SRC_X;
          default: c.src = SRC_NONE;
        endcase
      end
      4'd5, 4'd6: begin
        case (lane)
          2'd0: c.src = SRC_Z;
          2'd2: c.src = SRC_X;
          default: c.src = SRC_NONE;
        endcase
      end
      4'd7, 4'd8: begin
        case (lane)
          2'd1: c.src = SRC_Z;
          2'd2: c.src = SRC_Y;
          default: c.src = SRC_NONE;
        endcase
      end
      default: begin
        c.src = SRC_NONE;
      end
    endcase
    if (c.src == SRC_NONE) begin
      c.use_en = 1'b0;
    end
    return c;
  endfunction

endpackage

// ===== src/navier_stencil_relax_sweep_top.sv =====
`timescale 1ns / 1ps
// Interior voxel: 19 serial window reads on the single read port, then MAC drain, finish,
// squares and root steps, then write-back once the output register is free.
// Boundary voxel: own-voxel read, drain, write-back; no result (fill or flush): emit check only.
// The next beat is accepted while a finished result still waits on the output register.
// Reset (rst_n low, synchronous): control, counters and weights/sizes return to defaults;
// the window and force memories keep garbage and need no clearing pass.
module navier_stencil_relax_sweep_top #(
  parameter int MAX_X = 64,
  parameter int MAX_Y = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [nsrs_pkg::VW-1:0] in_vel_x,
  input  logic signed [nsrs_pkg::VW-1:0] in_vel_y,
  input  logic signed [nsrs_pkg::VW-1:0] in_vel_z,
  input  logic signed [nsrs_pkg::VW-1:0] in_force_x,
  input  logic signed [nsrs_pkg::VW-1:0] in_force_y,
  input  logic signed [nsrs_pkg::VW-1:0] in_force_z,
  input  logic                           in_flush,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [nsrs_pkg::VW-1:0] out_new_x,
  output logic signed [nsrs_pkg::VW-1:0] out_new_y,
  output logic signed [nsrs_pkg::VW-1:0] out_new_z,
  output logic [nsrs_pkg::VW-1:0]        out_change_norm,
  output logic                           out_last_voxel,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [nsrs_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [nsrs_pkg::CFG_DW-1:0]    cfg_data
);
  import nsrs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Config beats are always taken; a size write restarts the volume.
  assign cfg_ready = 1'b1;

  // Sequencer: accept, emit check, read walk over the 18 neighbors, finish, norm.
  nsrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  // Window/force memories, 3-lane MAC, rounding, shared squarer and root unit.
  nsrs_dp #(
    .MAX_X (MAX_X),
    .MAX_Y (MAX_Y)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_vel_x        (in_vel_x),
    .in_vel_y        (in_vel_y),
    .in_vel_z        (in_vel_z),
    .in_force_x      (in_force_x),
    .in_force_y      (in_force_y),
    .in_force_z      (in_force_z),
    .in_flush        (in_flush),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_new_x       (out_new_x),
    .out_new_y       (out_new_y),
    .out_new_z       (out_new_z),
    .out_change_norm (out_change_norm),
    .out_last_voxel  (out_last_voxel)
  );

endmodule

// ===== src/nsrs_ctrl.sv =====
`timescale 1ns / 1ps
module nsrs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  nsrs_pkg::stat_t stat_i,
  output nsrs_pkg::cmd_t  cmd_o
);
  import nsrs_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CHECK = 10'b0000000010,
    S_READ  = 10'b0000000100,
    S_DRAIN = 10'b0000001000,
    S_FIN1  = 10'b0000010000,
    S_FIN2  = 10'b0000100000,
    S_FIN3  = 10'b0001000000,
    S_SQ    = 10'b0010000000,
    S_ROOT  = 10'b0100000000,
    S_WB    = 10'b1000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd_o     = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.take = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.emit_ok) begin
          cmd_o.acc_clr = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = S_READ;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        cmd_o.rd_issue = 1'b1;
        cmd_o.rd_step  = cnt_r;
        if ((cnt_r == '0 && stat_i.boundary) || cnt_r == LAST_STEP) begin
          cnt_nxt   = '0;
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_DRAIN: begin
        if (cnt_r == DRAIN_LAST) begin
          cnt_nxt   = '0;
          state_nxt = stat_i.boundary ? S_WB : S_FIN1;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_FIN1: begin
        cmd_o.fin1 = 1'b1;
        state_nxt  = S_FIN2;
      end
      S_FIN2: begin
        cmd_o.fin2 = 1'b1;
        state_nxt  = S_FIN3;
      end
      S_FIN3: begin
        cmd_o.fin3 = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = S_SQ;
      end
      S_SQ: begin
        cmd_o.sq_en  = 1'b1;
        cmd_o.sq_idx = cnt_r[1:0];
        if (cnt_r == SQ_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_ROOT;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_ROOT: begin
        if (cnt_r == '0) begin
          cmd_o.root_init = 1'b1;
        end else begin
          cmd_o.root_step = 1'b1;
        end
        if (cnt_r == ROOT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_WB;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_WB: begin
        if (stat_i.out_free) begin
          cmd_o.wb  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_take_check: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.take |=> state_r == S_CHECK) else $error("take not followed by check");

  a_read_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ && cnt_r == LAST_STEP) |=> state_r == S_DRAIN)
    else $error("read sequence overran");

  a_bnd_short: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN && cnt_r == DRAIN_LAST && stat_i.boundary) |=> state_r == S_WB)
    else $error("boundary voxel took the arithmetic path");

endmodule

// ===== src/nsrs_dp.sv =====
`timescale 1ns / 1ps
module nsrs_dp #(
  parameter int MAX_X = 64,
  parameter int MAX_Y = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  nsrs_pkg::cmd_t                    cmd_i,
  output nsrs_pkg::stat_t                   stat_o,
  input  logic                              cfg_we,
  input  logic [nsrs_pkg::CFG_IW-1:0]       cfg_index,
  input  logic [nsrs_pkg::CFG_DW-1:0]       cfg_data,
  input  logic signed [nsrs_pkg::VW-1:0]    in_vel_x,
  input  logic signed [nsrs_pkg::VW-1:0]    in_vel_y,
  input  logic signed [nsrs_pkg::VW-1:0]    in_vel_z,
  input  logic signed [nsrs_pkg::VW-1:0]    in_force_x,
  input  logic signed [nsrs_pkg::VW-1:0]    in_force_y,
  input  logic signed [nsrs_pkg::VW-1:0]    in_force_z,
  input  logic                              in_flush,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [nsrs_pkg::VW-1:0]    out_new_x,
  output logic signed [nsrs_pkg::VW-1:0]    out_new_y,
  output logic signed [nsrs_pkg::VW-1:0]    out_new_z,
  output logic [nsrs_pkg::VW-1:0]           out_change_norm,
  output logic                              out_last_voxel
);
  import nsrs_pkg::*;

  localparam int WIN = 2 * MAX_X * MAX_Y + 2 * MAX_X + 3;
  localparam int FRC = MAX_X * MAX_Y + MAX_X + 1;
  localparam int AW  = $clog2(WIN);
  localparam int FAW = $clog2(FRC);
  localparam int XW  = $clog2(MAX_X + 1);
  localparam int YW  = $clog2(MAX_Y + 1);
  localparam int PW  = $clog2(MAX_X * MAX_Y + 1);
  localparam int LW  = PW + 1;
  localparam int TW  = PW + SZ_W;
  localparam int CW  = TW + 1;
  localparam int AW1 = AW + 1;
  localparam int MW  = 3 * VW;

  // configuration
  logic [COEF_W-1:0] coef_pair_r, coef_face_r, coef_cross_r;
  logic [SXY_W-1:0]  size_x_r, size_y_r;
  logic [SZ_W-1:0]   size_z_r;
  logic              size_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_pair_r  <= 16'd21845;
      coef_face_r  <= 16'd5461;
      coef_cross_r <= 16'd4096;
      size_x_r     <= 7'd64;
      size_y_r     <= 7'd64;
      size_z_r     <= 13'd64;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_COEF_PAIR:  coef_pair_r  <= cfg_data;
        REG_COEF_FACE:  coef_face_r  <= cfg_data;
        REG_COEF_CROSS: coef_cross_r <= cfg_data;
        REG_SIZE_X:     size_x_r     <= cfg_data[SXY_W-1:0];
        REG_SIZE_Y:     size_y_r     <= cfg_data[SXY_W-1:0];
        REG_SIZE_Z:     size_z_r     <= cfg_data[SZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(cfg_index))
      REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z: size_wr = cfg_we;
      default: size_wr = 1'b0;
    endcase
  end

  // clamped geometry
  logic [XW-1:0]   sx;
  logic [YW-1:0]   sy;
  logic [SZ_W-1:0] sz;
  logic [PW-1:0]   plane;
  logic [LW-1:0]   lat;
  logic [TW-1:0]   total;

  always_comb begin
    sx = (size_x_r < 7'd3) ? XW'(3) :
         ((32'(size_x_r) > 32'(MAX_X)) ? XW'(MAX_X) : XW'(size_x_r));
    sy = (size_y_r < 7'd3) ? YW'(3) :
         ((32'(size_y_r) > 32'(MAX_Y)) ? YW'(MAX_Y) : YW'(size_y_r));
    sz = (size_z_r < 13'd3) ? 13'd3 :
         ((size_z_r > 13'(LIMIT_Z)) ? 13'(LIMIT_Z) : size_z_r);
    plane = PW'(sx) * PW'(sy);
    lat   = LW'(plane) + LW'(sx);
    total = TW'(plane) * TW'(sz);
  end

  // counters and pointers
  logic [CW-1:0]   items_r, emitted_r;
  logic [AW-1:0]   wptr_r, eptr_r;
  logic [FAW-1:0]  fptr_r, efptr_r;
  logic [XW-1:0]   ex_r;
  logic [YW-1:0]   ey_r;
  logic [SZ_W-1:0] ez_r;
  logic            p_lt_total, take_wr, take_adv, last_c, boundary_c;

  assign p_lt_total = items_r < CW'(total);
  assign take_wr    = cmd_i.take && p_lt_total && !in_flush;
  assign take_adv   = cmd_i.take && !(p_lt_total && in_flush);
  assign last_c     = (ex_r == XW'(sx - 1'b1)) && (ey_r == YW'(sy - 1'b1)) &&
                      (ez_r == sz - 13'd1);
  assign boundary_c = (ex_r == '0) || (ex_r == XW'(sx - 1'b1)) ||
                      (ey_r == '0) || (ey_r == YW'(sy - 1'b1)) ||
                      (ez_r == '0) || (ez_r == sz - 13'd1);

  always_ff @(posedge clk) begin
    if (!rst_n || size_wr || (cmd_i.wb && last_c)) begin
      items_r   <= '0;
      emitted_r <= '0;
      wptr_r    <= '0;
      eptr_r    <= '0;
      fptr_r    <= '0;
      efptr_r   <= '0;
      ex_r      <= '0;
      ey_r      <= '0;
      ez_r      <= '0;
    end else begin
      if (take_adv) begin
        items_r <= items_r + CW'(1);
        wptr_r  <= (wptr_r == AW'(WIN - 1)) ? '0 : wptr_r + AW'(1);
        fptr_r  <= (fptr_r == FAW'(FRC - 1)) ? '0 : fptr_r + FAW'(1);
      end
      if (cmd_i.wb) begin
        emitted_r <= emitted_r + CW'(1);
        eptr_r    <= (eptr_r == AW'(WIN - 1)) ? '0 : eptr_r + AW'(1);
        efptr_r   <= (efptr_r == FAW'(FRC - 1)) ? '0 : efptr_r + FAW'(1);
        if (ex_r == XW'(sx - 1'b1)) begin
          ex_r <= '0;
          if (ey_r == YW'(sy - 1'b1)) begin
            ey_r <= '0;
            ez_r <= ez_r + 13'd1;
          end else begin
            ey_r <= ey_r + YW'(1);
          end
        end else begin
          ex_r <= ex_r + XW'(1);
        end
      end
    end
  end

  // neighbor address
  logic [4:0]  nb;
  logic [AW-1:0] mag, raddr;
  logic [AW1-1:0] asum;
  logic        aneg;

  always_comb begin
    nb   = cmd_i.rd_step - 5'd1;
    aneg = (nb[4:1] == 4'd4) ? nb[0] : ~nb[0];
    case (nb[4:1])
      4'd0: mag = AW'(1);
      4'd1: mag = AW'(sx);
      4'd2: mag = AW'(plane);
      4'd3: mag = AW'(sx) + AW'(1);
      4'd4: mag = AW'(sx) - AW'(1);
      4'd5: mag = AW'(plane) + AW'(1);
      4'd6: mag = AW'(plane) - AW'(1);
      4'd7: mag = AW'(plane) + AW'(sx);
      4'd8: mag = AW'(plane) - AW'(sx);
      default: mag = '0;
    endcase
    if (aneg) begin
      asum = (eptr_r >= mag) ? AW1'(eptr_r - mag)
                             : AW1'(eptr_r) + AW1'(WIN) - AW1'(mag);
    end else begin
      asum = AW1'(eptr_r) + AW1'(mag);
      if (asum >= AW1'(WIN)) begin
        asum = asum - AW1'(WIN);
      end
    end
    raddr = (cmd_i.rd_step == '0) ? eptr_r : asum[AW-1:0];
  end

  // memories
  logic [MW-1:0] win_mem [WIN];
  logic [MW-1:0] frc_mem [FRC];
  logic [MW-1:0] win_rd_r, frc_rd_r, win_wdata, res_c;
  logic          win_we;
  logic [AW-1:0] win_waddr;

  assign win_we    = take_wr || cmd_i.wb;
  assign win_waddr = cmd_i.wb ? eptr_r : wptr_r;
  assign win_wdata = cmd_i.wb ? res_c : {in_vel_z, in_vel_y, in_vel_x};

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[win_waddr] <= win_wdata;
    end
    if (cmd_i.rd_issue) begin
      win_rd_r <= win_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (take_wr) begin
      frc_mem[fptr_r] <= {in_force_z, in_force_y, in_force_x};
    end
    if (cmd_i.rd_issue && cmd_i.rd_step == '0) begin
      frc_rd_r <= frc_mem[efptr_r];
    end
  end

  // multiply-accumulate pipeline
  logic                     t1_v_r, t2_v_r;
  logic [4:0]               t1_step_r;
  logic [2:0]               t2_neg_r;
  logic signed [VW-1:0]     old_r  [3];
  logic signed [PROD_W-1:0] prod_r [3];
  logic signed [PROD_W-1:0] prod_c [3];
  logic [2:0]               neg_c;
  logic signed [ACC_W-1:0]  acc_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r <= 1'b0;
      t2_v_r <= 1'b0;
    end else begin
      t1_v_r <= cmd_i.rd_issue;
      t2_v_r <= t1_v_r && (t1_step_r != '0);
    end
  end

  always_comb begin
    lane_ctl_t            lc;
    logic signed [VW-1:0] v;
    logic signed [COEF_W:0] cf;
    for (int k = 0; k < 3; k++) begin
      lc = lane_ctl(t1_step_r - 5'd1, 2'(k));
      case (lc.src)
        SRC_X:   v = win_rd_r[VW-1:0];
        SRC_Y:   v = win_rd_r[2*VW-1:VW];
        SRC_Z:   v = win_rd_r[3*VW-1:2*VW];
        default: v = '0;
      endcase
      case (lc.csel)
        CSEL_PAIR: cf = {1'b0, coef_pair_r};
        CSEL_FACE: cf = {1'b0, coef_face_r};
        default:   cf = {1'b0, coef_cross_r};
      endcase
      prod_c[k] = cf * v;
      neg_c[k]  = lc.neg;
    end
  end

  always_ff @(posedge clk) begin
    t1_step_r <= cmd_i.rd_step;
    t2_neg_r  <= neg_c;
    for (int k = 0; k < 3; k++) begin
      prod_r[k] <= prod_c[k];
    end
    if (t1_v_r && t1_step_r == '0) begin
      old_r[0] <= win_rd_r[VW-1:0];
      old_r[1] <= win_rd_r[2*VW-1:VW];
      old_r[2] <= win_rd_r[3*VW-1:2*VW];
    end
    for (int k = 0; k < 3; k++) begin
      if (cmd_i.acc_clr) begin
        acc_r[k] <= '0;
      end else if (t2_v_r) begin
        acc_r[k] <= t2_neg_r[k] ? acc_r[k] - ACC_W'(prod_r[k])
                                : acc_r[k] + ACC_W'(prod_r[k]);
      end
    end
  end

  // rounding, saturation, change magnitude
  logic signed [SUM_W-1:0] sum_r [3];
  logic signed [VW-1:0]    new_r [3];
  logic [VW:0]             ad_r  [3];
  logic signed [VW-1:0]    frc_c [3];
  logic signed [ACC_W-1:0] rnd_c [3];
  logic signed [VW:0]      d_c   [3];

  always_comb begin
    frc_c[0] = frc_rd_r[VW-1:0];
    frc_c[1] = frc_rd_r[2*VW-1:VW];
    frc_c[2] = frc_rd_r[3*VW-1:2*VW];
    for (int k = 0; k < 3; k++) begin
      rnd_c[k] = (acc_r[k] + ACC_W'(32768)) >>> 16;
      d_c[k]   = (VW+1)'(new_r[k]) - (VW+1)'(old_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd_i.fin1) begin
        sum_r[k] <= SUM_W'(rnd_c[k]) + SUM_W'(frc_c[k]);
      end
      if (cmd_i.fin2) begin
        if (sum_r[k] > SUM_W'(32'sh7FFFFFFF)) begin
          new_r[k] <= 32'sh7FFFFFFF;
        end else if (sum_r[k] < SUM_W'(-33'sh80000000)) begin
          new_r[k] <= 32'sh80000000;
        end else begin
          new_r[k] <= sum_r[k][VW-1:0];
        end
      end
      if (cmd_i.fin3) begin
        ad_r[k] <= (d_c[k] < 0) ? 33'(-d_c[k]) : 33'(d_c[k]);
      end
    end
  end

  // sum of squares, one shared multiplier
  logic [2*VW-1:0] q_r;
  logic [SQ_W-1:0] sumsq_r;
  logic            ovf_r;
  logic [VW:0]     sq_op;

  always_comb begin
    case (cmd_i.sq_idx)
      2'd0:    sq_op = ad_r[0];
      2'd1:    sq_op = ad_r[1];
      2'd2:    sq_op = ad_r[2];
      default: sq_op = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_i.fin3) begin
      sumsq_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd_i.sq_en) begin
      q_r   <= sq_op[VW-1:0] * sq_op[VW-1:0];
      ovf_r <= ovf_r | sq_op[VW];
      if (cmd_i.sq_idx != 2'd0) begin
        sumsq_r <= sumsq_r + SQ_W'(q_r);
      end
    end
  end

  // square root, two result bits per cycle
  logic [REM_W-1:0]  rem_r, rem_c, rem2, trial;
  logic [VW-1:0]     root_r, root_c;
  logic [2*VW-1:0]   n_r, n_c;

  always_comb begin
    rem_c  = rem_r;
    root_c = root_r;
    n_c    = n_r;
    rem2   = '0;
    trial  = '0;
    for (int i = 0; i < 2; i++) begin
      rem2  = {rem_c[REM_W-3:0], n_c[2*VW-1:2*VW-2]};
      trial = {1'b0, root_c, 2'b01};
      if (rem2 >= trial) begin
        rem_c  = rem2 - trial;
        root_c = {root_c[VW-2:0], 1'b1};
      end else begin
        rem_c  = rem2;
        root_c = {root_c[VW-2:0], 1'b0};
      end
      n_c = {n_c[2*VW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.root_init) begin
      rem_r  <= '0;
      root_r <= '0;
      n_r    <= sumsq_r[2*VW-1:0];
    end else if (cmd_i.root_step) begin
      rem_r  <= rem_c;
      root_r <= root_c;
      n_r    <= n_c;
    end
  end

  // result and output register
  logic [VW-1:0] norm_c;
  logic          out_valid_r;

  always_comb begin
    if (boundary_c) begin
      res_c  = {old_r[2], old_r[1], old_r[0]};
      norm_c = '0;
    end else begin
      res_c  = {new_r[2], new_r[1], new_r[0]};
      norm_c = (ovf_r || sumsq_r[SQ_W-1:2*VW] != '0) ? '1 : root_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.wb) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.wb) begin
      out_new_x       <= res_c[VW-1:0];
      out_new_y       <= res_c[2*VW-1:VW];
      out_new_z       <= res_c[3*VW-1:2*VW];
      out_change_norm <= norm_c;
      out_last_voxel  <= last_c;
    end
  end

  assign out_valid       = out_valid_r;
  assign stat_o.emit_ok  = (emitted_r + CW'(lat)) < items_r;
  assign stat_o.boundary = boundary_c;
  assign stat_o.out_free = !out_valid_r || out_ready;

  a_wb_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.wb |=> out_valid_r) else $error("written-back voxel not presented");

endmodule

// ===== tb/navier_stencil_relax_sweep_top_tb.sv =====
`timescale 1ns / 1ps
// Raster-order 3D stencil sweep: a local predictor keeps its own window, force delay line,
// weights and extents, and scores every output beat against the oldest predicted voxel.
module navier_stencil_relax_sweep_top_tb;
  import nsrs_pkg::*;

  localparam int WIN_D = 2 * 64 * 64 + 2 * 64 + 3;
  localparam int FRC_D = 64 * 64 + 64 + 1;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE = 60;  // longer than the interior voxel latency
  localparam int RAND_ITEMS = 450;
  localparam logic signed [31:0] VMX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] VMN = 32'sh80000000;

  typedef struct {
    logic signed [31:0] vx, vy, vz, fx, fy, fz;
    logic flush;
  } voxel_in_t;

  typedef struct {
    logic signed [31:0] nx, ny, nz;
    logic [31:0] norm;
    logic last;
  } voxel_out_t;

  // Directed beat plus, where obvious, the row whose velocity comes back unchanged
  // (boundary voxel pass-through, zero change); -1 = left to the predictor.
  typedef struct {
    logic signed [31:0] vx, vy, vz, fx, fy, fz;
    logic flush;
    int pass_row;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_vel_x = '0, in_vel_y = '0, in_vel_z = '0;
  logic signed [31:0] in_force_x = '0, in_force_y = '0, in_force_z = '0;
  logic in_flush = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_new_x, out_new_y, out_new_z;
  logic [31:0] out_change_norm;
  logic out_last_voxel;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  navier_stencil_relax_sweep_top DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---- predictor state ----
  int vel[3][WIN_D];
  int frc[3][FRC_D];
  int unsigned taken, emitted;
  bit [15:0] w_pair, w_face, w_cross;
  bit [6:0] ext_x, ext_y;
  bit [12:0] ext_z;
  bit volume_done;

  voxel_out_t pending_vox[$];
  voxel_out_t want;
  int errors = 0;
  int cycles = 0;
  int send_idle = 33, recv_idle = 58;
  int rand_count = 0;

  plan_row_t plan[25] = '{
    '{0, 0, 0, 0, 0, 0, 1, -1},  // flush while filling: dropped
    '{VMX, VMN, 0, VMX, VMN, -1, 0, -1},
    '{VMN, VMX, -1, VMN, VMX, 0, 0, -1},
    '{-1, 0, VMX, 0, -1, VMN, 0, -1},
    '{32'sh00010000, 32'shFFFF0000, 32'sh00008000, 1, -1, 2, 0, -1},
    '{32'sh55555555, 32'shAAAAAAAA, 32'sh0F0F0F0F, -2, 3, 4, 0, -1},
    '{32'shF0F0F0F0, 32'sh12345678, 32'shEDCBA987, 0, 0, 0, 0, -1},
    '{1, 2, 3, 4, 5, 6, 0, -1},
    '{-7, -8, -9, 10, 11, 12, 0, -1},
    '{VMX, VMX, VMX, VMX, VMX, VMX, 0, -1},
    '{VMN, VMN, VMN, VMN, VMN, VMN, 0, -1},
    '{32'sh00123456, -32'sh00654321, 32'sh00ABCDEF, 100, -100, 7, 0, -1},
    '{-1, -1, -1, -1, -1, -1, 0, -1},
    '{0, 0, 0, VMX, VMN, 0, 0, 1},
    '{32'sh00030000, 32'sh00020000, -32'sh00010000, 5, 5, 5, 0, 2},
    '{32'sh7FFF0000, 32'sh80010000, 32'sh00000001, 0, 0, 0, 0, 3},
    '{-32'sh00000100, 32'sh00000200, -32'sh00000300, 9, 8, 7, 0, 4},
    '{32'sh0A0A0A0A, 32'shA0A0A0A0, 32'sh3C3C3C3C, 1, 1, 1, 0, 5},
    '{VMX, 0, VMN, 0, VMX, 0, 0, 6},
    '{32'sh00001000, 32'sh00002000, 32'sh00004000, 0, 0, 0, 0, 7},
    '{-32'sh00001000, -32'sh00002000, -32'sh00004000, 2, 2, 2, 0, 8},
    '{32'sh01000000, 32'sh02000000, 32'sh04000000, -3, -3, -3, 0, 9},
    '{VMN, VMX, VMN, VMN, VMX, VMN, 0, 10},
    '{32'sh00000042, 32'sh00000043, 32'sh00000044, 0, 0, 0, 0, 11},
    '{32'sh0000FFFF, 32'shFFFF0001, 32'sh00010001, 6, 6, 6, 0, 12}
  };

  function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int unsigned vol_total();
    return clip(ext_x, 3, 64) * clip(ext_y, 3, 64) * clip(ext_z, 3, LIMIT_Z);
  endfunction

  function automatic longint pr(int k, longint pos, longint a, longint b);
    return longint'(vel[k][(pos + a) % WIN_D]) + longint'(vel[k][(pos + b) % WIN_D]);
  endfunction

  // divide by 2^16, halves go toward +inf
  function automatic longint rnd16(longint a);
    if (a >= 0) return (a + 32768) >>> 16;
    return -((-a + 32767) >>> 16);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000000000000000;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic relax_predict(input voxel_in_t it, output bit got, output voxel_out_t r);
    int unsigned sx, sy, sz, plane, total, lat, p, e, x, y, z;
    int wi, k;
    longint pos, dx, dxy, acc, d;
    longint old[3], nw[3], s1[3], s2[3], cr[3], fr[3];
    longint unsigned ad, root;
    bit [65:0] sq;
    got = 1'b0;
    r = '{default: 0};
    sx = clip(ext_x, 3, 64);
    sy = clip(ext_y, 3, 64);
    sz = clip(ext_z, 3, LIMIT_Z);
    plane = sx * sy;
    total = plane * sz;
    lat = plane + sx;
    p = taken;
    if (p < total) begin
      if (it.flush) return;
      wi = p % WIN_D;
      vel[0][wi] = it.vx;
      vel[1][wi] = it.vy;
      vel[2][wi] = it.vz;
      frc[0][p % FRC_D] = it.fx;
      frc[1][p % FRC_D] = it.fy;
      frc[2][p % FRC_D] = it.fz;
    end
    taken = p + 1;
    if (!(emitted + lat < taken)) return;
    e = emitted;
    x = e % sx;
    y = (e / sx) % sy;
    z = e / plane;
    wi = e % WIN_D;
    for (k = 0; k < 3; k++) old[k] = vel[k][wi];
    if (x == 0 || x == sx - 1 || y == 0 || y == sy - 1 || z == 0 || z == sz - 1) begin
      for (k = 0; k < 3; k++) nw[k] = old[k];
    end else begin
      pos = e;
      dx = sx;
      dxy = plane;
      for (k = 0; k < 3; k++) begin
        s1[k] = pr(k, pos, -1, 1);
        s2[k] = pr(k, pos, -dx, dx) + pr(k, pos, -dxy, dxy);
        fr[k] = frc[k][e % FRC_D];
      end
      // mixed-derivative terms
      cr[0] = pr(1, pos, -dx - 1, dx + 1) + pr(2, pos, -dxy - 1, dxy + 1)
            - pr(1, pos, dx - 1, -dx + 1) - pr(2, pos, -dxy + 1, dxy - 1);
      cr[1] = pr(0, pos, -dx - 1, dx + 1) + pr(2, pos, -dxy - dx, dxy + dx)
            - pr(0, pos, dx - 1, -dx + 1) - pr(2, pos, -dxy + dx, dxy - dx);
      cr[2] = pr(0, pos, -dxy - 1, dxy + 1) + pr(1, pos, -dxy - dx, dxy + dx)
            - pr(0, pos, -dxy + 1, dxy - 1) - pr(1, pos, -dxy + dx, dxy - dx);
      sq = '0;
      for (k = 0; k < 3; k++) begin
        acc = longint'(w_pair) * s1[k] + longint'(w_face) * s2[k]
            + longint'(w_cross) * cr[k];
        nw[k] = sat32(fr[k] + rnd16(acc));
        d = nw[k] - old[k];
        ad = d < 0 ? -d : d;
        sq += {2'b00, ad * ad};
      end
      root = isqrt(sq[63:0]);
      r.norm = (sq[65:64] != 0 || root > 64'hFFFFFFFF) ? 32'hFFFFFFFF : root[31:0];
    end
    for (k = 0; k < 3; k++) vel[k][wi] = int'(nw[k]);
    r.nx = nw[0][31:0];
    r.ny = nw[1][31:0];
    r.nz = nw[2][31:0];
    got = 1'b1;
    if (e == total - 1) begin
      r.last = 1'b1;
      taken = 0;
      emitted = 0;
      volume_done = 1'b1;
    end else begin
      emitted = e + 1;
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_COEF_PAIR:  w_pair = val;
      REG_COEF_FACE:  w_face = val;
      REG_COEF_CROSS: w_cross = val;
      REG_SIZE_X: begin ext_x = val[6:0]; taken = 0; emitted = 0; end
      REG_SIZE_Y: begin ext_y = val[6:0]; taken = 0; emitted = 0; end
      REG_SIZE_Z: begin ext_z = val[12:0]; taken = 0; emitted = 0; end
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [15:0] p, f, c, sx, sy, sz);
    write_reg(REG_COEF_PAIR, p);
    write_reg(REG_COEF_FACE, f);
    write_reg(REG_COEF_CROSS, c);
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
  endtask

  // Drive one beat; returns once accepted, with the predicted result if any.
  task automatic send_voxel(input voxel_in_t it, output bit got, output voxel_out_t r);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_vel_x <= it.vx;
    in_vel_y <= it.vy;
    in_vel_z <= it.vz;
    in_force_x <= it.fx;
    in_force_y <= it.fy;
    in_force_z <= it.fz;
    in_flush <= it.flush;
    do @(posedge clk); while (!in_ready);
    relax_predict(it, got, r);
  endtask

  // Sender holds off until all results are back, then lets the pipe settle.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_vox.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return VMX;
      1: return VMN;
      2, 3: return $urandom;
      default: return int'($urandom_range(0, 1 << 20)) - (1 << 19);
    endcase
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return $urandom_range(0, 16'h3FFF);
    endcase
  endfunction

  // Random volume traffic; stops at the volume end, or after stop_after beats if nonzero.
  task automatic run_volume(input int stop_after);
    voxel_in_t it;
    voxel_out_t r;
    bit got, filling;
    int n;
    n = 0;
    volume_done = 1'b0;
    while (!volume_done && (stop_after == 0 || n < stop_after)) begin
      // idle schedule: receiver-heavy, then sender-heavy, then none
      if (rand_count < RAND_ITEMS / 3) begin
        send_idle = 33; recv_idle = 58;
      end else if (rand_count < 2 * RAND_ITEMS / 3) begin
        send_idle = 58; recv_idle = 33;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      filling = taken < vol_total();
      it.vx = rand_word();
      it.vy = rand_word();
      it.vz = rand_word();
      it.fx = rand_word();
      it.fy = rand_word();
      it.fz = rand_word();
      // stray flushes while filling; after fill, voxel beats also drain
      it.flush = filling ? ($urandom_range(0, 99) < 8) : $urandom_range(0, 1);
      send_voxel(it, got, r);
      if (got) pending_vox.push_back(r);
      if (!(filling && it.flush)) rand_count++;
      n++;
    end
    quiesce();
  endtask

  // Scoreboard on the result channel; out_ready toggles at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_vox.size() == 0) begin
          $display("%0t: unexpected beat x=%h y=%h z=%h", $time, out_new_x, out_new_y,
                   out_new_z);
          errors++;
        end else begin
          want = pending_vox.pop_front();
          if (out_new_x !== want.nx || out_new_y !== want.ny || out_new_z !== want.nz ||
              out_change_norm !== want.norm || out_last_voxel !== want.last) begin
            $display("%0t: mismatch expected x=%h y=%h z=%h norm=%h last=%b", $time,
                     want.nx, want.ny, want.nz, want.norm, want.last);
            $display("%0t:          actual   x=%h y=%h z=%h norm=%h last=%b", $time,
                     out_new_x, out_new_y, out_new_z, out_change_norm, out_last_voxel);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    voxel_in_t it;
    voxel_out_t r;
    bit got;
    int i;
    int left;
    w_pair = 16'd21845;
    w_face = 16'd5461;
    w_cross = 16'd4096;
    ext_x = 7'd64;
    ext_y = 7'd64;
    ext_z = 13'd64;
    taken = 0;
    emitted = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 3x3x3 volume at reset weights
    write_reg(REG_SIZE_X, 16'd3);
    write_reg(REG_SIZE_Y, 16'd3);
    write_reg(REG_SIZE_Z, 16'd3);
    for (i = 0; i < 25; i++) begin
      it = '{plan[i].vx, plan[i].vy, plan[i].vz, plan[i].fx, plan[i].fy, plan[i].fz,
             plan[i].flush};
      send_voxel(it, got, r);
      if (plan[i].pass_row >= 0) begin
        pending_vox.push_back('{plan[plan[i].pass_row].vx, plan[plan[i].pass_row].vy,
                                plan[plan[i].pass_row].vz, 32'd0, 1'b0});
      end else if (got) begin
        pending_vox.push_back(r);
      end
    end
    run_volume(0);  // rest of the directed volume, random fill

    // extreme settings
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd5, 16'd4, 16'd4);
    run_volume(0);
    write_all(16'h0000, 16'h0000, 16'h0000, 16'd4, 16'd3, 16'd3);
    run_volume(0);
    // out-of-range extents clamp up to 3: 2, 1 and 0 all act as 3
    write_all(rand_coef(), rand_coef(), rand_coef(), 16'd2, 16'd1, 16'd0);
    run_volume(0);
    write_all(rand_coef(), rand_coef(), rand_coef(), 16'd0, 16'd3, 16'd2);
    run_volume(0);
    // deepest volume, abandoned part way by the next extent write
    write_all(rand_coef(), rand_coef(), rand_coef(), 16'd3, 16'd3, 16'd8191);
    run_volume(40);

    while (rand_count < RAND_ITEMS) begin
      write_all(rand_coef(), rand_coef(), rand_coef(), $urandom_range(3, 6),
                $urandom_range(3, 5), $urandom_range(3, 5));
      left = RAND_ITEMS - rand_count;
      run_volume(($urandom_range(0, 5) == 0) ? $urandom_range(5, 60) : left);
    end

    if (errors == 0 && pending_vox.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/nsrs_pkg.sv
src/nsrs_ctrl.sv
src/nsrs_dp.sv
src/navier_stencil_relax_sweep_top.sv
tb/navier_stencil_relax_sweep_top_tb.sv
